// ===== design/orb_pkg.sv =====
// Shared types and constants for the oriented brief core.
package orb_pkg;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DIVIDE,
      ST_TRIG,
      ST_TEST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [26:0] dividend;
      logic [26:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [26:0] quotient;
   } div_rsp_type;

   localparam int TestCount  = 256;
   localparam int WordBits   = 64;
   localparam int DivBits    = 27;

   // Test offsets packed as x1,y1,x2,y2, each 8-bit two's complement.
   function automatic logic [31:0] test_pair(input logic [7:0] idx);
      logic [31:0] r;
      begin
         unique case (idx)
            8'd0: r = {8'sd8, -8'sd3, 8'sd9, 8'sd5};
            8'd1: r = {8'sd4, 8'sd2, 8'sd7, -8'sd12};
            8'd2: r = {-8'sd11, 8'sd9, -8'sd8, 8'sd2};
            8'd3: r = {8'sd7, -8'sd12, 8'sd12, -8'sd13};
            8'd4: r = {8'sd2, -8'sd13, 8'sd2, 8'sd12};
            8'd5: r = {8'sd1, -8'sd7, 8'sd1, 8'sd6};
            8'd6: r = {-8'sd2, -8'sd10, -8'sd2, -8'sd4};
            8'd7: r = {-8'sd13, -8'sd13, -8'sd11, -8'sd8};
            8'd8: r = {-8'sd13, -8'sd3, -8'sd12, -8'sd9};
            8'd9: r = {8'sd10, 8'sd4, 8'sd11, 8'sd9};
            8'd10: r = {-8'sd13, -8'sd8, -8'sd8, -8'sd9};
            8'd11: r = {-8'sd11, 8'sd7, -8'sd9, 8'sd12};
            8'd12: r = {8'sd7, 8'sd7, 8'sd12, 8'sd6};
            8'd13: r = {-8'sd4, -8'sd5, -8'sd3, 8'sd0};
            8'd14: r = {-8'sd13, 8'sd2, -8'sd12, -8'sd3};
            8'd15: r = {-8'sd9, 8'sd0, -8'sd7, 8'sd5};
            8'd16: r = {8'sd12, -8'sd6, 8'sd12, -8'sd1};
            8'd17: r = {-8'sd3, 8'sd6, -8'sd2, 8'sd12};
            8'd18: r = {-8'sd6, -8'sd13, -8'sd4, -8'sd8};
            8'd19: r = {8'sd11, -8'sd13, 8'sd12, -8'sd8};
            8'd20: r = {8'sd4, 8'sd7, 8'sd5, 8'sd1};
            8'd21: r = {8'sd5, -8'sd3, 8'sd10, -8'sd3};
            8'd22: r = {8'sd3, -8'sd7, 8'sd6, 8'sd12};
            8'd23: r = {-8'sd8, -8'sd7, -8'sd6, -8'sd2};
            8'd24: r = {-8'sd2, 8'sd11, -8'sd1, -8'sd10};
            8'd25: r = {-8'sd13, 8'sd12, -8'sd8, 8'sd10};
            8'd26: r = {-8'sd7, 8'sd3, -8'sd5, -8'sd3};
            8'd27: r = {-8'sd4, 8'sd2, -8'sd3, 8'sd7};
            8'd28: r = {-8'sd10, -8'sd12, -8'sd6, 8'sd11};
            8'd29: r = {8'sd5, -8'sd12, 8'sd6, -8'sd7};
            8'd30: r = {8'sd5, -8'sd6, 8'sd7, -8'sd1};
            8'd31: r = {8'sd1, 8'sd0, 8'sd4, -8'sd5};
            8'd32: r = {8'sd9, 8'sd11, 8'sd11, -8'sd13};
            8'd33: r = {8'sd4, 8'sd7, 8'sd4, 8'sd12};
            8'd34: r = {8'sd2, -8'sd1, 8'sd4, 8'sd4};
            8'd35: r = {-8'sd4, -8'sd12, -8'sd2, 8'sd7};
            8'd36: r = {-8'sd8, -8'sd5, -8'sd7, -8'sd10};
            8'd37: r = {8'sd4, 8'sd11, 8'sd9, 8'sd12};
            8'd38: r = {8'sd0, -8'sd8, 8'sd1, -8'sd13};
            8'd39: r = {-8'sd13, -8'sd2, -8'sd8, 8'sd2};
            8'd40: r = {-8'sd3, -8'sd2, -8'sd2, 8'sd3};
            8'd41: r = {-8'sd6, 8'sd9, -8'sd4, -8'sd9};
            8'd42: r = {8'sd8, 8'sd12, 8'sd10, 8'sd7};
            8'd43: r = {8'sd0, 8'sd9, 8'sd1, 8'sd3};
            8'd44: r = {8'sd7, -8'sd5, 8'sd11, -8'sd10};
            8'd45: r = {-8'sd13, -8'sd6, -8'sd11, 8'sd0};
            8'd46: r = {8'sd10, 8'sd7, 8'sd12, 8'sd1};
            8'd47: r = {-8'sd6, -8'sd3, -8'sd6, 8'sd12};
            8'd48: r = {8'sd10, -8'sd9, 8'sd12, -8'sd4};
            8'd49: r = {-8'sd13, 8'sd8, -8'sd8, -8'sd12};
            8'd50: r = {-8'sd13, 8'sd0, -8'sd8, -8'sd4};
            8'd51: r = {8'sd3, 8'sd3, 8'sd7, 8'sd8};
            8'd52: r = {8'sd5, 8'sd7, 8'sd10, -8'sd7};
            8'd53: r = {-8'sd1, 8'sd7, 8'sd1, -8'sd12};
            8'd54: r = {8'sd3, -8'sd10, 8'sd5, 8'sd6};
            8'd55: r = {8'sd2, -8'sd4, 8'sd3, -8'sd10};
            8'd56: r = {-8'sd13, 8'sd0, -8'sd13, 8'sd5};
            8'd57: r = {-8'sd13, -8'sd7, -8'sd12, 8'sd12};
            8'd58: r = {-8'sd13, 8'sd3, -8'sd11, 8'sd8};
            8'd59: r = {-8'sd7, 8'sd12, -8'sd4, 8'sd7};
            8'd60: r = {8'sd6, -8'sd10, 8'sd12, 8'sd8};
            8'd61: r = {-8'sd9, -8'sd1, -8'sd7, -8'sd6};
            8'd62: r = {-8'sd2, -8'sd5, 8'sd0, 8'sd12};
            8'd63: r = {-8'sd12, 8'sd5, -8'sd7, 8'sd5};
            8'd64: r = {8'sd3, -8'sd10, 8'sd8, -8'sd13};
            8'd65: r = {-8'sd7, -8'sd7, -8'sd4, 8'sd5};
            8'd66: r = {-8'sd3, -8'sd2, -8'sd1, -8'sd7};
            8'd67: r = {8'sd2, 8'sd9, 8'sd5, -8'sd11};
            8'd68: r = {-8'sd11, -8'sd13, -8'sd5, -8'sd13};
            8'd69: r = {-8'sd1, 8'sd6, 8'sd0, -8'sd1};
            8'd70: r = {8'sd5, -8'sd3, 8'sd5, 8'sd2};
            8'd71: r = {-8'sd4, -8'sd13, -8'sd4, 8'sd12};
            8'd72: r = {-8'sd9, -8'sd6, -8'sd9, 8'sd6};
            8'd73: r = {-8'sd12, -8'sd10, -8'sd8, -8'sd4};
            8'd74: r = {8'sd10, 8'sd2, 8'sd12, -8'sd3};
            8'd75: r = {8'sd7, 8'sd12, 8'sd12, 8'sd12};
            8'd76: r = {-8'sd7, -8'sd13, -8'sd6, 8'sd5};
            8'd77: r = {-8'sd4, 8'sd9, -8'sd3, 8'sd4};
            8'd78: r = {8'sd7, -8'sd1, 8'sd12, 8'sd2};
            8'd79: r = {-8'sd7, 8'sd6, -8'sd5, 8'sd1};
            8'd80: r = {-8'sd13, 8'sd11, -8'sd12, 8'sd5};
            8'd81: r = {-8'sd3, 8'sd7, -8'sd2, -8'sd6};
            8'd82: r = {8'sd7, -8'sd8, 8'sd12, -8'sd7};
            8'd83: r = {-8'sd13, -8'sd7, -8'sd11, -8'sd12};
            8'd84: r = {8'sd1, -8'sd3, 8'sd12, 8'sd12};
            8'd85: r = {8'sd2, -8'sd6, 8'sd3, 8'sd0};
            8'd86: r = {-8'sd4, 8'sd3, -8'sd2, -8'sd13};
            8'd87: r = {-8'sd1, -8'sd13, 8'sd1, 8'sd9};
            8'd88: r = {8'sd7, 8'sd1, 8'sd8, -8'sd6};
            8'd89: r = {8'sd1, -8'sd1, 8'sd3, 8'sd12};
            8'd90: r = {8'sd9, 8'sd1, 8'sd12, 8'sd6};
            8'd91: r = {-8'sd1, -8'sd9, -8'sd1, 8'sd3};
            8'd92: r = {-8'sd13, -8'sd13, -8'sd10, 8'sd5};
            8'd93: r = {8'sd7, 8'sd7, 8'sd10, 8'sd12};
            8'd94: r = {8'sd12, -8'sd5, 8'sd12, 8'sd9};
            8'd95: r = {8'sd6, 8'sd3, 8'sd7, 8'sd11};
            8'd96: r = {8'sd5, -8'sd13, 8'sd6, 8'sd10};
            8'd97: r = {8'sd2, -8'sd12, 8'sd2, 8'sd3};
            8'd98: r = {8'sd3, 8'sd8, 8'sd4, -8'sd6};
            8'd99: r = {8'sd2, 8'sd6, 8'sd12, -8'sd13};
            8'd100: r = {8'sd9, -8'sd12, 8'sd10, 8'sd3};
            8'd101: r = {-8'sd8, 8'sd4, -8'sd7, 8'sd9};
            8'd102: r = {-8'sd11, 8'sd12, -8'sd4, -8'sd6};
            8'd103: r = {8'sd1, 8'sd12, 8'sd2, -8'sd8};
            8'd104: r = {8'sd6, -8'sd9, 8'sd7, -8'sd4};
            8'd105: r = {8'sd2, 8'sd3, 8'sd3, -8'sd2};
            8'd106: r = {8'sd6, 8'sd3, 8'sd11, 8'sd0};
            8'd107: r = {8'sd3, -8'sd3, 8'sd8, -8'sd8};
            8'd108: r = {8'sd7, 8'sd8, 8'sd9, 8'sd3};
            8'd109: r = {-8'sd11, -8'sd5, -8'sd6, -8'sd4};
            8'd110: r = {-8'sd10, 8'sd11, -8'sd5, 8'sd10};
            8'd111: r = {-8'sd5, -8'sd8, -8'sd3, 8'sd12};
            8'd112: r = {-8'sd10, 8'sd5, -8'sd9, 8'sd0};
            8'd113: r = {8'sd8, -8'sd1, 8'sd12, -8'sd6};
            8'd114: r = {8'sd4, -8'sd6, 8'sd6, -8'sd11};
            8'd115: r = {-8'sd10, 8'sd12, -8'sd8, 8'sd7};
            8'd116: r = {8'sd4, -8'sd2, 8'sd6, 8'sd7};
            8'd117: r = {-8'sd2, 8'sd0, -8'sd2, 8'sd12};
            8'd118: r = {-8'sd5, -8'sd8, -8'sd5, 8'sd2};
            8'd119: r = {8'sd7, -8'sd6, 8'sd10, 8'sd12};
            8'd120: r = {-8'sd9, -8'sd13, -8'sd8, -8'sd8};
            8'd121: r = {-8'sd5, -8'sd13, -8'sd5, -8'sd2};
            8'd122: r = {8'sd8, -8'sd8, 8'sd9, -8'sd13};
            8'd123: r = {-8'sd9, -8'sd11, -8'sd9, 8'sd0};
            8'd124: r = {8'sd1, -8'sd8, 8'sd1, -8'sd2};
            8'd125: r = {8'sd7, -8'sd4, 8'sd9, 8'sd1};
            8'd126: r = {-8'sd2, 8'sd1, -8'sd1, -8'sd4};
            8'd127: r = {8'sd11, -8'sd6, 8'sd12, -8'sd11};
            8'd128: r = {-8'sd12, -8'sd9, -8'sd6, 8'sd4};
            8'd129: r = {8'sd3, 8'sd7, 8'sd7, 8'sd12};
            8'd130: r = {8'sd5, 8'sd5, 8'sd10, 8'sd8};
            8'd131: r = {8'sd0, -8'sd4, 8'sd2, 8'sd8};
            8'd132: r = {-8'sd9, 8'sd12, -8'sd5, -8'sd13};
            8'd133: r = {8'sd0, 8'sd7, 8'sd2, 8'sd12};
            8'd134: r = {-8'sd1, 8'sd2, 8'sd1, 8'sd7};
            8'd135: r = {8'sd5, 8'sd11, 8'sd7, -8'sd9};
            8'd136: r = {8'sd3, 8'sd5, 8'sd6, -8'sd8};
            8'd137: r = {-8'sd13, -8'sd4, -8'sd8, 8'sd9};
            8'd138: r = {-8'sd5, 8'sd9, -8'sd3, -8'sd3};
            8'd139: r = {-8'sd4, -8'sd7, -8'sd3, -8'sd12};
            8'd140: r = {8'sd6, 8'sd5, 8'sd8, 8'sd0};
            8'd141: r = {-8'sd7, 8'sd6, -8'sd6, 8'sd12};
            8'd142: r = {-8'sd13, 8'sd6, -8'sd5, -8'sd2};
            8'd143: r = {8'sd1, -8'sd10, 8'sd3, 8'sd10};
            8'd144: r = {8'sd4, 8'sd1, 8'sd8, -8'sd4};
            8'd145: r = {-8'sd2, -8'sd2, 8'sd2, -8'sd13};
            8'd146: r = {8'sd2, -8'sd12, 8'sd12, 8'sd12};
            8'd147: r = {-8'sd2, -8'sd13, 8'sd0, -8'sd6};
            8'd148: r = {8'sd4, 8'sd1, 8'sd9, 8'sd3};
            8'd149: r = {-8'sd6, -8'sd10, -8'sd3, -8'sd5};
            8'd150: r = {-8'sd3, -8'sd13, -8'sd1, 8'sd1};
            8'd151: r = {8'sd7, 8'sd5, 8'sd12, -8'sd11};
            8'd152: r = {8'sd4, -8'sd2, 8'sd5, -8'sd7};
            8'd153: r = {-8'sd13, 8'sd9, -8'sd9, -8'sd5};
            8'd154: r = {8'sd7, 8'sd1, 8'sd8, 8'sd6};
            8'd155: r = {8'sd7, -8'sd8, 8'sd7, 8'sd6};
            8'd156: r = {-8'sd7, -8'sd4, -8'sd7, 8'sd1};
            8'd157: r = {-8'sd8, 8'sd11, -8'sd7, -8'sd8};
            8'd158: r = {-8'sd13, 8'sd6, -8'sd12, -8'sd8};
            8'd159: r = {8'sd2, 8'sd4, 8'sd3, 8'sd9};
            8'd160: r = {8'sd10, -8'sd5, 8'sd12, 8'sd3};
            8'd161: r = {-8'sd6, -8'sd5, -8'sd6, 8'sd7};
            8'd162: r = {8'sd8, -8'sd3, 8'sd9, -8'sd8};
            8'd163: r = {8'sd2, -8'sd12, 8'sd2, 8'sd8};
            8'd164: r = {-8'sd11, -8'sd2, -8'sd10, 8'sd3};
            8'd165: r = {-8'sd12, -8'sd13, -8'sd7, -8'sd9};
            8'd166: r = {-8'sd11, 8'sd0, -8'sd10, -8'sd5};
            8'd167: r = {8'sd5, -8'sd3, 8'sd11, 8'sd8};
            8'd168: r = {-8'sd2, -8'sd13, -8'sd1, 8'sd12};
            8'd169: r = {-8'sd1, -8'sd8, 8'sd0, 8'sd9};
            8'd170: r = {-8'sd13, -8'sd11, -8'sd12, -8'sd5};
            8'd171: r = {-8'sd10, -8'sd2, -8'sd10, 8'sd11};
            8'd172: r = {-8'sd3, 8'sd9, -8'sd2, -8'sd13};
            8'd173: r = {8'sd2, -8'sd3, 8'sd3, 8'sd2};
            8'd174: r = {-8'sd9, -8'sd13, -8'sd4, 8'sd0};
            8'd175: r = {-8'sd4, 8'sd6, -8'sd3, -8'sd10};
            8'd176: r = {-8'sd4, 8'sd12, -8'sd2, -8'sd7};
            8'd177: r = {-8'sd6, -8'sd11, -8'sd4, 8'sd9};
            8'd178: r = {8'sd6, -8'sd3, 8'sd6, 8'sd11};
            8'd179: r = {-8'sd13, 8'sd11, -8'sd5, 8'sd5};
            8'd180: r = {8'sd11, 8'sd11, 8'sd12, 8'sd6};
            8'd181: r = {8'sd7, -8'sd5, 8'sd12, -8'sd2};
            8'd182: r = {-8'sd1, 8'sd12, 8'sd0, 8'sd7};
            8'd183: r = {-8'sd4, -8'sd8, -8'sd3, -8'sd2};
            8'd184: r = {-8'sd7, 8'sd1, -8'sd6, 8'sd7};
            8'd185: r = {-8'sd13, -8'sd12, -8'sd8, -8'sd13};
            8'd186: r = {-8'sd7, -8'sd2, -8'sd6, -8'sd8};
            8'd187: r = {-8'sd8, 8'sd5, -8'sd6, -8'sd9};
            8'd188: r = {-8'sd5, -8'sd1, -8'sd4, 8'sd5};
            8'd189: r = {-8'sd13, 8'sd7, -8'sd8, 8'sd10};
            8'd190: r = {8'sd1, 8'sd5, 8'sd5, -8'sd13};
            8'd191: r = {8'sd1, 8'sd0, 8'sd10, -8'sd13};
            8'd192: r = {8'sd9, 8'sd12, 8'sd10, -8'sd1};
            8'd193: r = {8'sd5, -8'sd8, 8'sd10, -8'sd9};
            8'd194: r = {-8'sd1, 8'sd11, 8'sd1, -8'sd13};
            8'd195: r = {-8'sd9, -8'sd3, -8'sd6, 8'sd2};
            8'd196: r = {-8'sd1, -8'sd10, 8'sd1, 8'sd12};
            8'd197: r = {-8'sd13, 8'sd1, -8'sd8, -8'sd10};
            8'd198: r = {8'sd8, -8'sd11, 8'sd10, -8'sd6};
            8'd199: r = {8'sd2, -8'sd13, 8'sd3, -8'sd6};
            8'd200: r = {8'sd7, -8'sd13, 8'sd12, -8'sd9};
            8'd201: r = {-8'sd10, -8'sd10, -8'sd5, -8'sd7};
            8'd202: r = {-8'sd10, -8'sd8, -8'sd8, -8'sd13};
            8'd203: r = {8'sd4, -8'sd6, 8'sd8, 8'sd5};
            8'd204: r = {8'sd3, 8'sd12, 8'sd8, -8'sd13};
            8'd205: r = {-8'sd4, 8'sd2, -8'sd3, -8'sd3};
            8'd206: r = {8'sd5, -8'sd13, 8'sd10, -8'sd12};
            8'd207: r = {8'sd4, -8'sd13, 8'sd5, -8'sd1};
            8'd208: r = {-8'sd9, 8'sd9, -8'sd4, 8'sd3};
            8'd209: r = {8'sd0, 8'sd3, 8'sd3, -8'sd9};
            8'd210: r = {-8'sd12, 8'sd1, -8'sd6, 8'sd1};
            8'd211: r = {8'sd3, 8'sd2, 8'sd4, -8'sd8};
            8'd212: r = {-8'sd10, -8'sd10, -8'sd10, 8'sd9};
            8'd213: r = {8'sd8, -8'sd13, 8'sd12, 8'sd12};
            8'd214: r = {-8'sd8, -8'sd12, -8'sd6, -8'sd5};
            8'd215: r = {8'sd2, 8'sd2, 8'sd3, 8'sd7};
            8'd216: r = {8'sd10, 8'sd6, 8'sd11, -8'sd8};
            8'd217: r = {8'sd6, 8'sd8, 8'sd8, -8'sd12};
            8'd218: r = {-8'sd7, 8'sd10, -8'sd6, 8'sd5};
            8'd219: r = {-8'sd3, -8'sd9, -8'sd3, 8'sd9};
            8'd220: r = {-8'sd1, -8'sd13, -8'sd1, 8'sd5};
            8'd221: r = {-8'sd3, -8'sd7, -8'sd3, 8'sd4};
            8'd222: r = {-8'sd8, -8'sd2, -8'sd8, 8'sd3};
            8'd223: r = {8'sd4, 8'sd2, 8'sd12, 8'sd12};
            8'd224: r = {8'sd2, -8'sd5, 8'sd3, 8'sd11};
            8'd225: r = {8'sd6, -8'sd9, 8'sd11, -8'sd13};
            8'd226: r = {8'sd3, -8'sd1, 8'sd7, 8'sd12};
            8'd227: r = {8'sd11, -8'sd1, 8'sd12, 8'sd4};
            8'd228: r = {-8'sd3, 8'sd0, -8'sd3, 8'sd6};
            8'd229: r = {8'sd4, -8'sd11, 8'sd4, 8'sd12};
            8'd230: r = {8'sd2, -8'sd4, 8'sd2, 8'sd1};
            8'd231: r = {-8'sd10, -8'sd6, -8'sd8, 8'sd1};
            8'd232: r = {-8'sd13, 8'sd7, -8'sd11, 8'sd1};
            8'd233: r = {-8'sd13, 8'sd12, -8'sd11, -8'sd13};
            8'd234: r = {8'sd6, 8'sd0, 8'sd11, -8'sd13};
            8'd235: r = {8'sd0, -8'sd1, 8'sd1, 8'sd4};
            8'd236: r = {-8'sd13, 8'sd3, -8'sd9, -8'sd2};
            8'd237: r = {-8'sd9, 8'sd8, -8'sd6, -8'sd3};
            8'd238: r = {-8'sd13, -8'sd6, -8'sd8, -8'sd2};
            8'd239: r = {8'sd5, -8'sd9, 8'sd8, 8'sd10};
            8'd240: r = {8'sd2, 8'sd7, 8'sd3, -8'sd9};
            8'd241: r = {-8'sd1, -8'sd6, -8'sd1, -8'sd1};
            8'd242: r = {8'sd9, 8'sd5, 8'sd11, -8'sd2};
            8'd243: r = {8'sd11, -8'sd3, 8'sd12, -8'sd8};
            8'd244: r = {8'sd3, 8'sd0, 8'sd3, 8'sd5};
            8'd245: r = {-8'sd1, 8'sd4, 8'sd0, 8'sd10};
            8'd246: r = {8'sd3, -8'sd6, 8'sd4, 8'sd5};
            8'd247: r = {-8'sd13, 8'sd0, -8'sd10, 8'sd5};
            8'd248: r = {8'sd5, 8'sd8, 8'sd12, 8'sd11};
            8'd249: r = {8'sd8, 8'sd9, 8'sd9, -8'sd6};
            8'd250: r = {8'sd7, -8'sd4, 8'sd8, -8'sd12};
            8'd251: r = {-8'sd10, 8'sd4, -8'sd10, 8'sd9};
            8'd252: r = {8'sd7, 8'sd3, 8'sd12, 8'sd4};
            8'd253: r = {8'sd9, -8'sd7, 8'sd10, -8'sd2};
            8'd254: r = {8'sd7, 8'sd0, 8'sd12, -8'sd2};
            default: r = {-8'sd1, -8'sd6, 8'sd0, -8'sd11};
         endcase
         return r;
      end
   endfunction

endpackage

// ===== design/orb_ram.sv =====
// Generic single-port RAM with a registered read.
module orb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2809
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/orb_divider.sv =====
// Restoring divider producing one quotient bit per cycle.
module orb_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  orb_pkg::div_req_type req,
   output orb_pkg::div_rsp_type rsp
);

   localparam int N = orb_pkg::DivBits;

   logic [N-1:0]         quot_ff, quot_in;
   logic [N:0]           rem_ff, rem_in;
   logic [N-1:0]         div_ff, div_in;
   logic [$clog2(N):0]   cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [N:0]           trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[N-1:0], quot_ff[N-1]};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = trial - {1'b0, div_ff};
            quot_in = {quot_ff[N-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(N)+1)'(N-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

// ===== design/orb_orientation_and_brief_core.sv =====
// Oriented brief core: window load, centroid angle, rotated tests, descriptor output.
// Load: one pixel per cycle while the core is in its load state; the window memory takes a
// write every accepted transaction. After the last pixel the core divides for the centroid
// angle (no division when both moments are zero), sets up the trigonometry, runs the tests
// (two memory reads per test through the single RAM port), then emits four output words.
// Synchronous reset clears the control state, load position, moments and keys.
module orb_orientation_and_brief_core #(
   parameter int WINDOW_RADIUS = 26
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   input  logic        req_inside_image,
   input  logic [11:0] req_key_x,
   input  logic [11:0] req_key_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_descriptor_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic [8:0]  rsp_angle_degrees,
   output logic [11:0] rsp_out_key_x,
   output logic [11:0] rsp_out_key_y
);

   localparam int Side  = 2 * WINDOW_RADIUS + 1;
   localparam int Area  = Side * Side;
   localparam int AW    = $clog2(Area);
   localparam int CW    = $clog2(Side);
   localparam int MRad  = 15;

   orb_pkg::state_type state_ff, state_in;

   logic [AW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [CW-1:0]       row_ff, row_in;
   logic signed [23:0]  mx_ff, mx_in;
   logic signed [23:0]  my_ff, my_in;
   logic [11:0]         kx_ff, kx_in;
   logic [11:0]         ky_ff, ky_in;
   logic [8:0]          angle_ff, angle_in;
   logic [8:0]          base_ff, base_in;
   logic signed [9:0]   cos_ff, cos_in;
   logic signed [9:0]   sin_ff, sin_in;
   logic [1:0]          trig_ff, trig_in;
   logic [9:0]          tst_ff, tst_in;
   logic [7:0]          p1_ff, p1_in;
   logic [255:0]        bits_ff, bits_in;
   logic [1:0]          word_ff, word_in;
   logic                out_v_ff, out_v_in;

   logic                accept;
   logic                ram_we;
   logic [AW-1:0]       ram_addr;
   logic [7:0]          ram_rd;
   orb_pkg::div_req_type dreq;
   orb_pkg::div_rsp_type drsp;

   logic signed [6:0]   dx, dy;
   logic [10:0]         dist2;
   logic signed [16:0]  prod_x, prod_y;
   logic                in_disc;

   logic                mx_neg, my_neg;
   logic [23:0]         ax, ay;
   logic [24:0]         asum;
   logic [31:0]         te;
   logic [7:0]          tsel;
   logic                second;
   logic signed [7:0]   px, py;
   logic signed [17:0]  rx_q, ry_q;
   logic signed [9:0]   rx, ry;
   logic signed [10:0]  colc, rowc;
   logic [CW-1:0]       scol, srow;
   logic [AW-1:0]       samp_addr;
   logic [8:0]          a_rel;
   logic [19:0]         q8_num;
   logic [8:0]          q8_val;

   orb_ram #(.WIDTH(8), .DEPTH(Area)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(req_pixel),
      .rd_data(ram_rd)
   );

   orb_divider u_div (
      .clock(clock),
      .reset(reset),
      .req  (dreq),
      .rsp  (drsp)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != orb_pkg::ST_LOAD);
   assign ram_we    = accept;

   assign dx      = 7'(signed'({1'b0, col_ff})) - 7'(WINDOW_RADIUS);
   assign dy      = 7'(signed'({1'b0, row_ff})) - 7'(WINDOW_RADIUS);
   assign dist2   = 11'(11'(dx) * 11'(dx)) + 11'(11'(dy) * 11'(dy));
   assign in_disc = req_inside_image && (dist2 <= 11'(MRad * MRad));
   assign prod_x  = dx * signed'({1'b0, req_pixel});
   assign prod_y  = dy * signed'({1'b0, req_pixel});

   assign mx_neg = mx_ff[23];
   assign my_neg = my_ff[23];
   assign ax     = mx_neg ? 24'(-mx_ff) : 24'(mx_ff);
   assign ay     = my_neg ? 24'(-my_ff) : 24'(my_ff);
   assign asum   = 25'(ax) + 25'(ay) + 25'd1;

   // Sample address for the current test; the first sample of a pair on even steps.
   assign tsel   = tst_ff[8:1];
   assign second = tst_ff[0];
   assign te     = orb_pkg::test_pair(tsel);
   assign px     = second ? signed'(te[15:8]) : signed'(te[31:24]);
   assign py     = second ? signed'(te[7:0])  : signed'(te[23:16]);
   assign rx_q   = 18'(px) * 18'(cos_ff) - 18'(py) * 18'(sin_ff);
   assign ry_q   = 18'(px) * 18'(sin_ff) + 18'(py) * 18'(cos_ff);
   assign rx     = 10'(rx_q >>> 8);
   assign ry     = 10'(ry_q >>> 8);
   assign colc   = 11'(rx) + 11'(WINDOW_RADIUS);
   assign rowc   = 11'(ry) + 11'(WINDOW_RADIUS);
   assign scol   = colc[10] ? '0 : (colc > 11'(Side - 1)) ? CW'(Side - 1) : colc[CW-1:0];
   assign srow   = rowc[10] ? '0 : (rowc > 11'(Side - 1)) ? CW'(Side - 1) : rowc[CW-1:0];
   assign samp_addr = AW'(srow * Side) + AW'(scol);
   assign ram_addr  = (state_ff == orb_pkg::ST_LOAD) ? pos_ff : samp_addr;

   // Piecewise-linear Q8 sine magnitude within one 45-degree segment.
   always_comb begin
      if (angle_ff < 9'd45) begin
         a_rel = angle_ff;
      end else if (angle_ff < 9'd90) begin
         a_rel = 9'd90 - angle_ff;
      end else if (angle_ff < 9'd135) begin
         a_rel = angle_ff - 9'd90;
      end else if (angle_ff < 9'd180) begin
         a_rel = 9'd180 - angle_ff;
      end else if (angle_ff < 9'd225) begin
         a_rel = angle_ff - 9'd180;
      end else if (angle_ff < 9'd270) begin
         a_rel = 9'd270 - angle_ff;
      end else if (angle_ff < 9'd315) begin
         a_rel = angle_ff - 9'd270;
      end else begin
         a_rel = 9'd360 - angle_ff;
      end
   end

   assign q8_num = 20'(a_rel) * 20'd11651;
   assign q8_val = q8_num[19:11];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         orb_pkg::ST_LOAD:
            if (accept && pos_ff == AW'(Area - 1)) begin
               state_in = orb_pkg::ST_DIVIDE;
            end
         orb_pkg::ST_DIVIDE:
            if (drsp.done || (mx_ff == '0 && my_ff == '0)) begin
               state_in = orb_pkg::ST_TRIG;
            end
         orb_pkg::ST_TRIG:
            if (trig_ff == 2'd1) begin
               state_in = orb_pkg::ST_TEST;
            end
         orb_pkg::ST_TEST:
            if (tst_ff == 10'd512) begin
               state_in = orb_pkg::ST_EMIT;
            end
         orb_pkg::ST_EMIT:
            if (out_v_ff && !rsp_stall && word_ff == 2'd3) begin
               state_in = orb_pkg::ST_LOAD;
            end
         default: state_in = orb_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      pos_in   = pos_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      kx_in    = kx_ff;
      ky_in    = ky_ff;
      angle_in = angle_ff;
      base_in  = base_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      trig_in  = trig_ff;
      tst_in   = tst_ff;
      p1_in    = p1_ff;
      bits_in  = bits_ff;
      word_in  = word_ff;
      out_v_in = out_v_ff;
      dreq.start    = 1'b0;
      dreq.dividend = '0;
      dreq.divisor  = 27'(asum);
      unique case (state_ff)
         orb_pkg::ST_LOAD: begin
            if (accept) begin
               if (pos_ff == '0) begin
                  kx_in = req_key_x;
                  ky_in = req_key_y;
                  mx_in = in_disc ? 24'(prod_x) : '0;
                  my_in = in_disc ? 24'(prod_y) : '0;
               end else if (in_disc) begin
                  mx_in = mx_ff + 24'(prod_x);
                  my_in = my_ff + 24'(prod_y);
               end
               if (pos_ff == AW'(Area - 1)) begin
                  pos_in = '0;
                  col_in = '0;
                  row_in = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  if (col_ff == CW'(Side - 1)) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
            trig_in = '0;
            tst_in  = '0;
            word_in = '0;
         end
         orb_pkg::ST_DIVIDE: begin
            // The divider is started here on the first cycle with the quadrant numerator.
            if (!drsp.busy && !drsp.done) begin
               dreq.start = !(mx_ff == '0 && my_ff == '0);
            end
            if (!mx_neg && !my_neg) begin
               dreq.dividend = 27'(ay) * 27'd90;
               base_in = 9'd0;
            end else if (mx_neg && !my_neg) begin
               dreq.dividend = 27'(ax) * 27'd90;
               base_in = 9'd90;
            end else if (mx_neg && my_neg) begin
               dreq.dividend = 27'(ay) * 27'd90;
               base_in = 9'd180;
            end else begin
               dreq.dividend = 27'(ax) * 27'd90;
               base_in = 9'd270;
            end
            if (mx_ff == '0 && my_ff == '0) begin
               angle_in = '0;
            end else if (drsp.done) begin
               angle_in = base_ff + 9'(drsp.quotient);
            end
         end
         orb_pkg::ST_TRIG: begin
            trig_in = trig_ff + 1'b1;
            if (angle_ff < 9'd45) begin
               cos_in = 10'sd256;  sin_in = 10'(q8_val);
            end else if (angle_ff < 9'd90) begin
               cos_in = 10'(q8_val); sin_in = 10'sd256;
            end else if (angle_ff < 9'd135) begin
               cos_in = -10'(q8_val); sin_in = 10'sd256;
            end else if (angle_ff < 9'd180) begin
               cos_in = -10'sd256; sin_in = 10'(q8_val);
            end else if (angle_ff < 9'd225) begin
               cos_in = -10'sd256; sin_in = -10'(q8_val);
            end else if (angle_ff < 9'd270) begin
               cos_in = -10'(q8_val); sin_in = -10'sd256;
            end else if (angle_ff < 9'd315) begin
               cos_in = 10'(q8_val); sin_in = -10'sd256;
            end else begin
               cos_in = 10'sd256; sin_in = -10'(q8_val);
            end
         end
         orb_pkg::ST_TEST: begin
            // Read issued for one step returns on the step after it.
            tst_in = tst_ff + 1'b1;
            if (tst_ff != '0) begin
               if (tst_ff[0]) begin
                  p1_in = ram_rd;
               end else begin
                  bits_in[8'(tst_ff[9:1] - 1'b1)] = (p1_ff < ram_rd);
               end
            end
            if (tst_ff == 10'd512) begin
               out_v_in = 1'b1;
            end
         end
         orb_pkg::ST_EMIT: begin
            if (out_v_ff && !rsp_stall) begin
               word_in = word_ff + 1'b1;
               if (word_ff == 2'd3) begin
                  out_v_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= orb_pkg::ST_LOAD;
         pos_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         mx_ff    <= '0;
         my_ff    <= '0;
         kx_ff    <= '0;
         ky_ff    <= '0;
         trig_ff  <= '0;
         tst_ff   <= '0;
         word_ff  <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         kx_ff    <= kx_in;
         ky_ff    <= ky_in;
         trig_ff  <= trig_in;
         tst_ff   <= tst_in;
         word_ff  <= word_in;
         out_v_ff <= out_v_in;
      end
      angle_ff <= angle_in;
      base_ff  <= base_in;
      cos_ff   <= cos_in;
      sin_ff   <= sin_in;
      p1_ff    <= p1_in;
      bits_ff  <= bits_in;
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_descriptor_word = bits_ff[{word_ff, 6'd0} +: 64];
   assign rsp_word_index      = word_ff;
   assign rsp_last_word       = (word_ff == 2'd3);
   assign rsp_angle_degrees   = angle_ff;
   assign rsp_out_key_x       = kx_ff;
   assign rsp_out_key_y       = ky_ff;

   a_no_load_while_out: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> req_stall) else $error("input taken while descriptor pending");
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (angle_ff < 9'd360)) else $error("angle out of range");
   a_word_advance: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_stall && word_ff != 2'd3) |=> (out_v_ff && word_ff == $past(word_ff) + 2'd1))
      else $error("descriptor word order broken");

endmodule

// ===== test/orb_orientation_and_brief_core_tb.sv =====
// Testbench for the oriented brief core: whole windows in, four descriptor words out per window.
module orb_orientation_and_brief_core_tb;

   localparam int Radius = 26;
   localparam int Side   = 2 * Radius + 1;
   localparam int Area   = Side * Side;
   localparam int DiscR  = 15;
   localparam int NoCut  = -Radius - 1;

   typedef struct {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
      logic [8:0]  angle;
      logic [11:0] kx;
      logic [11:0] ky;
   } descriptor_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_pixel;
   logic        req_inside_image;
   logic [11:0] req_key_x;
   logic [11:0] req_key_y;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_descriptor_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;
   logic [8:0]  rsp_angle_degrees;
   logic [11:0] rsp_out_key_x;
   logic [11:0] rsp_out_key_y;

   orb_orientation_and_brief_core dut (.*);

   logic [7:0]     window_pixels [Area];
   int             load_pos;
   int             sum_x;
   int             sum_y;
   logic [11:0]    key_x_held;
   logic [11:0]    key_y_held;
   descriptor_type pending_words [$];
   int             error_count;
   int             window_count;
   int             word_count;
   bit             sender_busy_mode;
   bit             receiver_busy_mode;
   int             stall_left;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   function automatic int centroid_angle(input int mx, input int my);
      if (mx == 0 && my == 0) return 0;
      if (mx >= 0 && my >= 0) return (my * 90) / (mx + my + 1);
      if (mx < 0 && my >= 0) return 90 + ((-mx) * 90) / (-mx + my + 1);
      if (mx < 0 && my < 0) return 180 + ((-my) * 90) / (-mx - my + 1);
      return 270 + (mx * 90) / (mx - my + 1);
   endfunction

   function automatic logic [7:0] rotated_pixel(input int px, input int py,
                                                input int c, input int s);
      int col;
      int row;
      col = Radius + ((px * c - py * s) >>> 8);
      row = Radius + ((px * s + py * c) >>> 8);
      if (col < 0) col = 0;
      if (row < 0) row = 0;
      if (col > Side - 1) col = Side - 1;
      if (row > Side - 1) row = Side - 1;
      return window_pixels[row * Side + col];
   endfunction

   task automatic predict_descriptor();
      int a;
      int c;
      int s;
      logic [31:0] t;
      logic [63:0] words [4];
      descriptor_type d;
      a = centroid_angle(sum_x, sum_y);
      if (a < 45) begin c = 256; s = a * 256 / 45; end
      else if (a < 90) begin c = (90 - a) * 256 / 45; s = 256; end
      else if (a < 135) begin c = -((a - 90) * 256 / 45); s = 256; end
      else if (a < 180) begin c = -256; s = (180 - a) * 256 / 45; end
      else if (a < 225) begin c = -256; s = -((a - 180) * 256 / 45); end
      else if (a < 270) begin c = -((270 - a) * 256 / 45); s = -256; end
      else if (a < 315) begin c = (a - 270) * 256 / 45; s = -256; end
      else begin c = 256; s = -((360 - a) * 256 / 45); end
      for (int w = 0; w < 4; w++) words[w] = '0;
      for (int i = 0; i < orb_pkg::TestCount; i++) begin
         t = orb_pkg::test_pair(i[7:0]);
         if (rotated_pixel($signed(t[31:24]), $signed(t[23:16]), c, s) <
             rotated_pixel($signed(t[15:8]), $signed(t[7:0]), c, s))
            words[i / orb_pkg::WordBits][i % orb_pkg::WordBits] = 1'b1;
      end
      for (int w = 0; w < 4; w++) begin
         d.word = words[w];
         d.index = w[1:0];
         d.last = (w == 3);
         d.angle = a[8:0];
         d.kx = key_x_held;
         d.ky = key_y_held;
         pending_words.push_back(d);
      end
   endtask

   task automatic predict_pixel(input logic [7:0] p, input logic ins,
                                input logic [11:0] kx, input logic [11:0] ky);
      int dx;
      int dy;
      if (load_pos == 0) begin
         key_x_held = kx;
         key_y_held = ky;
         sum_x = 0;
         sum_y = 0;
      end
      window_pixels[load_pos] = p;
      dx = load_pos % Side - Radius;
      dy = load_pos / Side - Radius;
      if (ins && dx * dx + dy * dy <= DiscR * DiscR) begin
         sum_x += dx * int'(p);
         sum_y += dy * int'(p);
      end
      load_pos++;
      if (load_pos == Area) begin
         load_pos = 0;
         predict_descriptor();
      end
   endtask

   task automatic send_pixel(input logic [7:0] p, input logic ins,
                             input logic [11:0] kx, input logic [11:0] ky);
      int gap;
      gap = sender_busy_mode ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_pixel = p;
      req_inside_image = ins;
      req_key_x = kx;
      req_key_y = ky;
      do @(posedge clock); while (req_stall);
      predict_pixel(p, ins, kx, ky);
      @(negedge clock);
   endtask

   // Pixels follow a linear ramp; positions left of cut_x or above cut_y lie outside
   // the image and repeat the nearest edge pixel.
   task automatic send_window(input int gx, input int gy, input int base, input int noise,
                              input int cut_x, input int cut_y, input bit all_outside,
                              input logic [11:0] kx, input logic [11:0] ky);
      int dx;
      int dy;
      int v;
      logic ins;
      sender_busy_mode = $urandom_range(0, 3) != 0;
      receiver_busy_mode = $urandom_range(0, 3) != 0;
      for (int pos = 0; pos < Area; pos++) begin
         dx = pos % Side - Radius;
         dy = pos / Side - Radius;
         ins = !all_outside && dx >= cut_x && dy >= cut_y;
         if (dx < cut_x) dx = cut_x;
         if (dy < cut_y) dy = cut_y;
         v = base + 4 * (gx * dx + gy * dy);
         if (noise > 0) v += $urandom_range(0, 2 * noise) - noise;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         if (pos == 0) send_pixel(v[7:0], ins, kx, ky);
         else send_pixel(v[7:0], ins, 12'($urandom), 12'($urandom));
      end
      req_valid = 1'b0;
      window_count++;
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   task automatic test_flat_windows();
      send_window(0, 0, 0, 0, NoCut, NoCut, 1'b0, 12'd0, 12'd0);
      send_window(0, 0, 255, 0, NoCut, NoCut, 1'b0, 12'hFFF, 12'hFFF);
      send_window(3, -2, 128, 40, NoCut, NoCut, 1'b1, 12'hAAA, 12'h555);
   endtask

   task automatic test_octants();
      send_window(1, 0, 128, 0, NoCut, NoCut, 1'b0, 12'h555, 12'hAAA);
      send_window(0, 1, 128, 0, NoCut, NoCut, 1'b0, 12'd1, 12'd2);
      send_window(-1, 1, 128, 3, NoCut, NoCut, 1'b0, 12'd3, 12'd4);
      send_window(-1, 0, 128, 0, NoCut, NoCut, 1'b0, 12'd5, 12'd6);
      send_window(-1, -1, 128, 3, NoCut, NoCut, 1'b0, 12'd7, 12'd8);
      send_window(0, -1, 128, 0, NoCut, NoCut, 1'b0, 12'd9, 12'd10);
      send_window(2, -1, 128, 3, NoCut, NoCut, 1'b0, 12'd11, 12'd12);
   endtask

   task automatic test_image_border();
      send_window(1, 1, 100, 20, 0, NoCut, 1'b0, 12'd0, 12'd200);
      send_window(-1, 2, 100, 20, -10, 5, 1'b0, 12'd30, 12'd0);
   endtask

   task automatic test_random_windows();
      for (int n = 0; n < 8; n++) begin
         if (n == 4) wait_drained();
         send_window($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                     $urandom_range(0, 255), $urandom_range(0, 128),
                     ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40) - 20 : NoCut,
                     ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40) - 20 : NoCut,
                     $urandom_range(0, 9) == 0, 12'($urandom), 12'($urandom));
      end
   endtask

   always @(negedge clock) begin
      if (receiver_busy_mode && stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      descriptor_type d;
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left = $urandom_range(0, 7);
         word_count++;
         if (pending_words.size() == 0) begin
            report("unexpected descriptor word", rsp_descriptor_word, '0);
         end else begin
            d = pending_words.pop_front();
            if (rsp_descriptor_word !== d.word) report("descriptor_word", rsp_descriptor_word, d.word);
            if (rsp_word_index !== d.index) report("word_index", rsp_word_index, d.index);
            if (rsp_last_word !== d.last) report("last_word", rsp_last_word, d.last);
            if (rsp_angle_degrees !== d.angle) report("angle_degrees", rsp_angle_degrees, d.angle);
            if (rsp_out_key_x !== d.kx) report("out_key_x", rsp_out_key_x, d.kx);
            if (rsp_out_key_y !== d.ky) report("out_key_y", rsp_out_key_y, d.ky);
         end
      end
   end

   initial begin
      #40000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      req_inside_image = 1'b0;
      req_key_x = '0;
      req_key_y = '0;
      rsp_stall = 1'b0;
      stall_left = 0;
      load_pos = 0;
      sum_x = 0;
      sum_y = 0;
      key_x_held = '0;
      key_y_held = '0;
      error_count = 0;
      window_count = 0;
      word_count = 0;
      sender_busy_mode = 1'b0;
      receiver_busy_mode = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_flat_windows();
      test_octants();
      wait_drained();
      test_image_border();
      test_random_windows();
      wait_drained();
      repeat (1000) @(negedge clock);
      $display("Covered %0d windows: flat, all outside, every octant, image borders, random.",
               window_count);
      $display("Checked %0d descriptor words.", word_count);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
